// File: hw/rtl/nsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsd_pkg;

  // Sentence framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int MAX_FIELDS = 64;
  // Field counter stops at the smaller of MAX_FIELDS-1 and the 6-bit maximum
  localparam logic [5:0] FIELD_LIMIT = 6'(((MAX_FIELDS - 1) < 63) ? (MAX_FIELDS - 1) : 63);

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Sentence status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_BAD      = 2'd2;

  // {not_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/nmea_sentence_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// The result is registered: it appears on the output register in the cycle after the input transfer.
// Throughput: 1 character per cycle; input is taken whenever the output
//   register is empty or being drained in the same cycle.
// Reset (rst, synchronous, active high): leaves the sentence, clears all
//   parser state and drops out_valid.

module nmea_sentence_deframer
  import nsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // character input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_in,
  // result channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      data_byte,
  output logic [5:0]      field_index,
  output logic            field_empty,
  output logic [1:0]      sentence_status,
  output logic [7:0]      checksum_calc,
  output logic [7:0]      checksum_received
);

  // Parser state
  logic       in_sentence, in_sentence_next;
  logic       after_star, after_star_next;
  logic [7:0] running_xor, running_xor_next;
  logic [5:0] field_counter, field_counter_next;
  logic       field_has_bytes, field_has_bytes_next;
  logic [1:0] hex_digit_count, hex_digit_count_next;
  logic [7:0] received_sum, received_sum_next;
  logic       hex_bad, hex_bad_next;

  // Result of the current character
  logic       emit;
  logic [1:0] r_kind;
  logic [7:0] r_data;
  logic       r_empty;
  logic [1:0] r_status;
  logic [7:0] r_xor;
  logic [4:0] hex;
  logic       accept;

  // Output register frees up when empty or taken this cycle
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign hex      = hex_decode(byte_in);

  always_comb begin
    in_sentence_next     = in_sentence;
    after_star_next      = after_star;
    running_xor_next     = running_xor;
    field_counter_next   = field_counter;
    field_has_bytes_next = field_has_bytes;
    hex_digit_count_next = hex_digit_count;
    received_sum_next    = received_sum;
    hex_bad_next         = hex_bad;
    emit     = 1'b0;
    r_kind   = KIND_DATA;
    r_data   = 8'h00;
    r_empty  = 1'b0;
    r_status = STAT_OK;
    r_xor    = running_xor;

    if (byte_in == CH_DOLLAR) begin
      // '$' always (re)opens a sentence, dropping any open one silently
      in_sentence_next     = 1'b1;
      after_star_next      = 1'b0;
      running_xor_next     = 8'h00;
      field_counter_next   = 6'd0;
      field_has_bytes_next = 1'b0;
      hex_digit_count_next = 2'd0;
      received_sum_next    = 8'h00;
      hex_bad_next         = 1'b0;
    end else if (in_sentence && byte_in != CH_CR) begin
      if (byte_in == CH_LF) begin
        emit   = 1'b1;
        r_kind = KIND_END;
        if (!after_star || hex_bad || hex_digit_count != 2'd2) begin
          r_status = STAT_BAD;
        end else if (received_sum == running_xor) begin
          r_status = STAT_OK;
        end else begin
          r_status = STAT_MISMATCH;
        end
        in_sentence_next = 1'b0;
        after_star_next  = 1'b0;
      end else if (after_star) begin
        // checksum digits: anything but two hex digits marks it malformed
        if (hex[4] || hex_digit_count == 2'd2) begin
          hex_bad_next = 1'b1;
        end else begin
          received_sum_next    = {received_sum[3:0], hex[3:0]};
          hex_digit_count_next = hex_digit_count + 2'd1;
        end
      end else if (byte_in == CH_STAR) begin
        // '*' closes the last field and is not part of the checksum
        emit            = 1'b1;
        r_kind          = KIND_CLOSE;
        r_empty         = !field_has_bytes;
        after_star_next = 1'b1;
        field_has_bytes_next = 1'b0;
        if (field_counter < FIELD_LIMIT) begin
          field_counter_next = field_counter + 6'd1;
        end
      end else begin
        running_xor_next = running_xor ^ byte_in;
        r_xor            = running_xor ^ byte_in;
        emit             = 1'b1;
        if (byte_in == CH_COMMA) begin
          r_kind  = KIND_CLOSE;
          r_empty = !field_has_bytes;
          field_has_bytes_next = 1'b0;
          if (field_counter < FIELD_LIMIT) begin
            field_counter_next = field_counter + 6'd1;
          end
        end else begin
          r_kind = KIND_DATA;
          r_data = byte_in;
          field_has_bytes_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence     <= 1'b0;
      after_star      <= 1'b0;
      running_xor     <= 8'h00;
      field_counter   <= 6'd0;
      field_has_bytes <= 1'b0;
      hex_digit_count <= 2'd0;
      received_sum    <= 8'h00;
      hex_bad         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        in_sentence     <= in_sentence_next;
        after_star      <= after_star_next;
        running_xor     <= running_xor_next;
        field_counter   <= field_counter_next;
        field_has_bytes <= field_has_bytes_next;
        hex_digit_count <= hex_digit_count_next;
        received_sum    <= received_sum_next;
        hex_bad         <= hex_bad_next;
      end
      // output slot is refilled (or emptied) whenever it can take new data
      if (in_ready) begin
        out_valid <= accept && emit;
      end
    end
  end

  // Result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind              <= r_kind;
      data_byte         <= r_data;
      field_index       <= field_counter;
      field_empty       <= r_empty;
      sentence_status   <= r_status;
      checksum_calc     <= r_xor;
      checksum_received <= received_sum;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nsd_checker
  import nsd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] kind,
  input wire logic [7:0] data_byte,
  input wire logic [5:0] field_index,
  input wire logic       field_empty,
  input wire logic [1:0] sentence_status,
  input wire logic [7:0] checksum_calc,
  input wire logic [7:0] checksum_received
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
      && $stable(field_index) && $stable(field_empty) && $stable(sentence_status)
      && $stable(checksum_calc) && $stable(checksum_received))
    else $error("result changed while stalled");

  // input never stalls while the output slot is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_DATA || kind == KIND_CLOSE || kind == KIND_END)
    else $error("bad result kind");

  // data byte only on data results; status only on sentence end
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_DATA || data_byte == 8'h00)
      && (kind == KIND_END || sentence_status == STAT_OK))
    else $error("field not zero for this kind");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind nmea_sentence_deframer nsd_checker u_nsd_checker (.*);

`default_nettype wire
